### hw/rtl/jsu_pkg.sv
// Shared types, codes and decode helpers for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Width of the running byte offset inside a string
    localparam int OFFSET_WIDTH = 16;

    // Results one text byte can cause: up to three UTF-8 bytes and an error
    localparam int MAX_RESULTS = 4;
    localparam int CNT_WIDTH   = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_WIDTH  = $clog2(MAX_RESULTS);

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd0;
    localparam logic [2:0] ERR_CONTROL    = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
    localparam logic [2:0] ERR_SHORT_U    = 3'd4;
    localparam logic [2:0] ERR_OPEN_ESC   = 3'd5;
    localparam logic [2:0] ERR_UNTERM     = 3'd6;

    // Characters and limits
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [15:0] UTF8_MAX1   = 16'h007f;
    localparam logic [15:0] UTF8_MAX2   = 16'h07ff;
    localparam logic [7:0] UTF8_LEAD2   = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3   = 8'he0;
    localparam logic [7:0] UTF8_CONT    = 8'h80;

    // Parser phases
    typedef enum logic [2:0] {
        PH_AWAIT = 3'd0,
        PH_STR   = 3'd1,
        PH_ESC   = 3'd2,
        PH_HEX   = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    // One input transfer
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_text;
    } text_item_t;

    // One output transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
        logic [15:0] error_offset;
        logic        last;
    } result_item_t;

    // All results caused by one text byte, handed from parser to queue
    typedef struct packed {
        logic [CNT_WIDTH-1:0]                  count;
        result_item_t [MAX_RESULTS-1:0]        res;
    } result_bundle_t;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})
            r = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h61:8'h66]})
            r = {1'b1, 4'(b - 8'h57)};
        else if (b inside {[8'h41:8'h46]})
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    // Short escape decode: {valid, byte}
    function automatic logic [8:0] short_escape(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h22:   r = {1'b1, 8'h22};
            8'h5c:   r = {1'b1, 8'h5c};
            8'h2f:   r = {1'b1, 8'h2f};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0c};
            8'h6e:   r = {1'b1, 8'h0a};
            8'h72:   r = {1'b1, 8'h0d};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/jsu_parser.sv
// Parser state and single-pass decode of one text byte into a result bundle.
`default_nettype none

module jsu_parser (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire jsu_pkg::text_item_t     item,
    output jsu_pkg::result_bundle_t      bundle
);

    localparam logic [jsu_pkg::OFFSET_WIDTH-1:0] OFF_MAX = '1;

    jsu_pkg::phase_t                   phase_reg, phase_next;
    logic [1:0]                        hex_seen_reg, hex_seen_next;
    logic [15:0]                       cp_reg, cp_next;
    logic [jsu_pkg::OFFSET_WIDTH-1:0]  off_reg, off_next;

    logic [jsu_pkg::OFFSET_WIDTH-1:0]  off_taken;
    logic [jsu_pkg::OFFSET_WIDTH-1:0]  short_at;
    logic [4:0]                        hex;
    logic [8:0]                        esc;
    logic [15:0]                       cp_new;
    logic [1:0]                        hs_new;
    logic [jsu_pkg::CNT_WIDTH-1:0]     n;
    jsu_pkg::result_item_t [jsu_pkg::MAX_RESULTS-1:0] r;
    logic                              is_end;
    logic [7:0]                        b;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= jsu_pkg::PH_AWAIT;
            hex_seen_reg <= 2'd0;
            cp_reg       <= 16'd0;
            off_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hex_seen_reg <= hex_seen_next;
            cp_reg       <= cp_next;
            off_reg      <= off_next;
        end
    end

    // Decode one byte against the current phase
    always_comb
    begin
        b             = item.in_byte;
        is_end        = item.last_of_text;
        phase_next    = phase_reg;
        hex_seen_next = hex_seen_reg;
        cp_next       = cp_reg;
        off_next      = off_reg;
        n             = '0;
        r             = '0;
        off_taken     = (off_reg == OFF_MAX) ? off_reg : off_reg + 1'b1;
        hex           = jsu_pkg::hex_value(b);
        esc           = jsu_pkg::short_escape(b);
        cp_new        = {cp_reg[11:0], hex[3:0]};
        hs_new        = hex_seen_reg + 2'd1;
        short_at      = (off_taken >= jsu_pkg::OFFSET_WIDTH'(hs_new))
                      ? off_taken - jsu_pkg::OFFSET_WIDTH'(hs_new) : '0;

        case (phase_reg)
            jsu_pkg::PH_AWAIT:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    off_next   = jsu_pkg::OFFSET_WIDTH'(1);
                    phase_next = jsu_pkg::PH_STR;
                    if (is_end)
                    begin
                        r[0].kind         = jsu_pkg::KIND_ERROR;
                        r[0].error_code   = jsu_pkg::ERR_UNTERM;
                        r[0].error_offset = 16'd1;
                        n = 3'd1;
                    end
                end
                else
                begin
                    r[0].kind       = jsu_pkg::KIND_ERROR;
                    r[0].error_code = jsu_pkg::ERR_NO_QUOTE;
                    n = 3'd1;
                    phase_next = jsu_pkg::PH_DONE;
                end
            end
            jsu_pkg::PH_STR:
            begin
                off_next = off_taken;
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    r[0].kind  = jsu_pkg::KIND_CLOSED;
                    n = 3'd1;
                    phase_next = jsu_pkg::PH_DONE;
                end
                else if (b < jsu_pkg::CTRL_LIMIT)
                begin
                    r[0].kind         = jsu_pkg::KIND_ERROR;
                    r[0].error_code   = jsu_pkg::ERR_CONTROL;
                    r[0].error_offset = 16'(off_taken);
                    n = 3'd1;
                    phase_next = jsu_pkg::PH_DONE;
                end
                else if (b == jsu_pkg::CH_BACKSLASH)
                begin
                    if (is_end)
                    begin
                        r[0].kind         = jsu_pkg::KIND_ERROR;
                        r[0].error_code   = jsu_pkg::ERR_OPEN_ESC;
                        r[0].error_offset = 16'(off_taken);
                        n = 3'd1;
                    end
                    else
                        phase_next = jsu_pkg::PH_ESC;
                end
                else
                begin
                    r[0].kind      = jsu_pkg::KIND_DATA;
                    r[0].data_byte = b;
                    n = 3'd1;
                    if (is_end)
                    begin
                        r[1].kind         = jsu_pkg::KIND_ERROR;
                        r[1].error_code   = jsu_pkg::ERR_UNTERM;
                        r[1].error_offset = 16'(off_taken);
                        n = 3'd2;
                    end
                end
            end
            jsu_pkg::PH_ESC:
            begin
                off_next = off_taken;
                if (b == jsu_pkg::CH_U)
                begin
                    phase_next    = jsu_pkg::PH_HEX;
                    hex_seen_next = 2'd0;
                    cp_next       = 16'd0;
                    if (is_end)
                    begin
                        r[0].kind         = jsu_pkg::KIND_ERROR;
                        r[0].error_code   = jsu_pkg::ERR_SHORT_U;
                        r[0].error_offset = 16'(off_taken);
                        n = 3'd1;
                    end
                end
                else if (!esc[8])
                begin
                    r[0].kind         = jsu_pkg::KIND_ERROR;
                    r[0].error_code   = jsu_pkg::ERR_BAD_ESCAPE;
                    r[0].error_offset = 16'(off_taken);
                    n = 3'd1;
                    phase_next = jsu_pkg::PH_DONE;
                end
                else
                begin
                    r[0].kind      = jsu_pkg::KIND_DATA;
                    r[0].data_byte = esc[7:0];
                    n = 3'd1;
                    phase_next = jsu_pkg::PH_STR;
                    if (is_end)
                    begin
                        r[1].kind         = jsu_pkg::KIND_ERROR;
                        r[1].error_code   = jsu_pkg::ERR_UNTERM;
                        r[1].error_offset = 16'(off_taken);
                        n = 3'd2;
                    end
                end
            end
            jsu_pkg::PH_HEX:
            begin
                off_next = off_taken;
                if (!hex[4])
                begin
                    r[0].kind         = jsu_pkg::KIND_ERROR;
                    r[0].error_code   = jsu_pkg::ERR_BAD_HEX;
                    r[0].error_offset = 16'(off_taken);
                    n = 3'd1;
                    phase_next = jsu_pkg::PH_DONE;
                end
                else
                begin
                    cp_next = cp_new;
                    if (hex_seen_reg == 2'd3)
                    begin
                        // Fourth digit: emit the code point as UTF-8
                        hex_seen_next = 2'd0;
                        phase_next    = jsu_pkg::PH_STR;
                        if (cp_new <= jsu_pkg::UTF8_MAX1)
                        begin
                            r[0].data_byte = cp_new[7:0];
                            n = 3'd1;
                        end
                        else if (cp_new <= jsu_pkg::UTF8_MAX2)
                        begin
                            r[0].data_byte = jsu_pkg::UTF8_LEAD2 | {3'd0, cp_new[10:6]};
                            r[1].data_byte = jsu_pkg::UTF8_CONT | {2'd0, cp_new[5:0]};
                            n = 3'd2;
                        end
                        else
                        begin
                            r[0].data_byte = jsu_pkg::UTF8_LEAD3 | {4'd0, cp_new[15:12]};
                            r[1].data_byte = jsu_pkg::UTF8_CONT | {2'd0, cp_new[11:6]};
                            r[2].data_byte = jsu_pkg::UTF8_CONT | {2'd0, cp_new[5:0]};
                            n = 3'd3;
                        end
                        if (is_end)
                        begin
                            r[n[jsu_pkg::SLOT_WIDTH-1:0]].kind = jsu_pkg::KIND_ERROR;
                            r[n[jsu_pkg::SLOT_WIDTH-1:0]].error_code = jsu_pkg::ERR_UNTERM;
                            r[n[jsu_pkg::SLOT_WIDTH-1:0]].error_offset = 16'(off_taken);
                            n = n + 1'b1;
                        end
                    end
                    else
                    begin
                        hex_seen_next = hs_new;
                        if (is_end)
                        begin
                            // Short escape: point at the 'u'
                            r[0].kind         = jsu_pkg::KIND_ERROR;
                            r[0].error_code   = jsu_pkg::ERR_SHORT_U;
                            r[0].error_offset = 16'(short_at);
                            n = 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = jsu_pkg::PH_DONE;
            end
        endcase

        // End of text returns everything to reset
        if (is_end)
        begin
            phase_next    = jsu_pkg::PH_AWAIT;
            hex_seen_next = 2'd0;
            cp_next       = 16'd0;
            off_next      = '0;
        end

        bundle.count = n;
        bundle.res   = r;
    end

    // Checks
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_of_text |=> phase_reg == jsu_pkg::PH_AWAIT && off_reg == '0)
        else $error("parser state not cleared after end of text");

    a_bundle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> bundle.count <= jsu_pkg::CNT_WIDTH'(jsu_pkg::MAX_RESULTS))
        else $error("result bundle too large");

    // A bad hex digit ends the string with the digit count left as it was
    a_hex_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        hex_seen_reg != 2'd0 |->
            (phase_reg == jsu_pkg::PH_HEX || phase_reg == jsu_pkg::PH_DONE))
        else $error("hex digit count outside unicode escape");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == jsu_pkg::PH_DONE |-> bundle.count == '0)
        else $error("results after string end");

endmodule

`default_nettype wire

### hw/rtl/jsu_out_queue.sv
// Result register for one byte's bundle; one result per cycle while res_ready is high.
`default_nettype none

module jsu_out_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire jsu_pkg::result_bundle_t  bundle,
    output logic                          can_load,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output jsu_pkg::result_item_t         res_item
);

    logic [jsu_pkg::CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [jsu_pkg::SLOT_WIDTH-1:0] idx_reg, idx_next;
    jsu_pkg::result_item_t [jsu_pkg::MAX_RESULTS-1:0] slot_reg;
    logic                           take;

    assign res_valid = (cnt_reg != '0);
    assign take      = res_valid && res_ready;
    // Free next cycle if empty or the last pending result leaves now
    assign can_load  = (cnt_reg == '0)
                    || (cnt_reg == jsu_pkg::CNT_WIDTH'(1) && res_ready);

    // Count and read pointer
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = bundle.count;
            idx_next = '0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 1'b1;
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle.res;
    end

    // Current result, last marks the end of this byte's bundle
    always_comb
    begin
        res_item      = slot_reg[idx_reg];
        res_item.last = (cnt_reg == jsu_pkg::CNT_WIDTH'(1));
    end

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= jsu_pkg::CNT_WIDTH'(jsu_pkg::MAX_RESULTS))
        else $error("queue count out of range");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == '0 || (cnt_reg == jsu_pkg::CNT_WIDTH'(1) && take))
        else $error("bundle loaded over pending results");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, idx_reg} + cnt_reg) <= jsu_pkg::CNT_WIDTH'(jsu_pkg::MAX_RESULTS))
        else $error("read pointer past bundle");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take && !load |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count did not drop on transfer");

endmodule

`default_nettype wire

### hw/rtl/json_string_unescaper_core.sv
// JSON string unescaper top level: parser plus result queue.
//
// Takes one JSON text byte per transfer (opening quote first) and returns the
// unescaped string bytes, a closed marker, or an error with its offset; \uXXXX
// escapes come out as 1 to 3 UTF-8 bytes. A byte is accepted in the same cycle
// that it is decoded, and its results (0 to 4) are held in a result register
// and sent one per cycle while res_ready is high, the final one carrying last.
// Throughput is one byte per cycle while each byte gives at most one result and
// the output is taken; a byte that gives more results holds text_ready low
// while the queue drains. There is no reset sweep: the block is ready right
// after rst_n rises.
`default_nettype none

module json_string_unescaper_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   text_valid,
    output logic                        text_ready,
    input  wire jsu_pkg::text_item_t    text_item,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output jsu_pkg::result_item_t       res_item
);

    jsu_pkg::result_bundle_t bundle;
    logic                    accept;

    assign accept = text_valid && text_ready;

    // Byte decode and string state
    jsu_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (text_item),
        .bundle (bundle)
    );

    // Result register and serializer
    jsu_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .bundle    (bundle),
        .can_load  (text_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire
